### sv/assert_macros.svh
// Assertion helpers used by the frame core RTL of the frame receiver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, suspended while reset is high.
`define AFR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define AFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/afr_pkg.sv
package afr_pkg;

   // Frame layout and fixed byte values.
   localparam logic [3:0] FRAME_FULL  = 4'd8;   // bytes held before the checksum byte
   localparam logic [7:0] HDR0        = 8'h00;
   localparam logic [7:0] HDR1        = 8'h5A;
   localparam logic [7:0] BCAST_ADDR  = 8'hFF;
   localparam logic [7:0] NEEDED_LEN  = 8'd2;

   // Reset addresses of this node.
   localparam logic [15:0] DEFAULT_ADDR   = 16'hFFFE;
   localparam logic [7:0]  DEFAULT_GROUP  = DEFAULT_ADDR[15:8];
   localparam logic [7:0]  DEFAULT_DEVICE = DEFAULT_ADDR[7:0];

   // Positions in the frame store, which holds frame bytes 2 through 7.
   localparam int STORE_DEPTH = 6;
   localparam logic [2:0] POS_GROUP  = 3'd0;
   localparam logic [2:0] POS_DEVICE = 3'd1;
   localparam logic [2:0] POS_CMD    = 3'd2;
   localparam logic [2:0] POS_LEN    = 3'd3;
   localparam logic [2:0] POS_DHIGH  = 3'd4;
   localparam logic [2:0] POS_DLOW   = 3'd5;
   localparam logic [2:0] STORE_BASE = 3'd2;

   // Configuration register indexes.
   localparam logic CSR_OWN_GROUP  = 1'b0;
   localparam logic CSR_OWN_DEVICE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_OWN    = 3'd1,
      ST_BCAST  = 3'd2,
      ST_HDR    = 3'd3,
      ST_SHORT  = 3'd4,
      ST_CSUM   = 3'd5,
      ST_OTHER  = 3'd6,
      ST_BADLEN = 3'd7
   } status_type;

   typedef struct packed {
      logic       action;
      logic [7:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      status_type status;
      logic [7:0] command_code;
      logic [7:0] data_high;
      logic [7:0] data_low;
   } rsp_item_type;

endpackage

### sv/afr_channels.sv
// Input channel: one received byte or one timeout per item.
interface afr_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] rx_byte;

   modport source (output valid, action, rx_byte, input ready);
   modport sink   (input valid, action, rx_byte, output ready);
endinterface

// Result channel: one status item per input item.
interface afr_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [7:0] command_code;
   logic [7:0] data_high;
   logic [7:0] data_low;

   modport source (output valid, status, command_code, data_high, data_low, input ready);
   modport sink   (input valid, status, command_code, data_high, data_low, output ready);
endinterface

### sv/afr_frame_core.sv
`include "assert_macros.svh"

module afr_frame_core
   import afr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_item_type item,
   input  logic [7:0]   own_group,
   input  logic [7:0]   own_device,
   output rsp_item_type result
);

   logic [3:0] byte_count_ff, byte_count_in;
   logic [7:0] running_sum_ff, running_sum_in;
   logic [7:0] frame_ff [STORE_DEPTH];
   logic       store_we;
   logic [2:0] store_idx;
   logic       addr_own, addr_bcast, len_ok;

   // Address and length checks on the held frame bytes.
   assign addr_own   = (frame_ff[POS_GROUP] == own_group) && (frame_ff[POS_DEVICE] == own_device);
   assign addr_bcast = (frame_ff[POS_GROUP] == BCAST_ADDR) && (frame_ff[POS_DEVICE] == BCAST_ADDR);
   assign len_ok     = (frame_ff[POS_LEN] == NEEDED_LEN);
   assign store_idx  = byte_count_ff[2:0] - STORE_BASE;

   // Per-item frame update and classification.
   always_comb begin
      byte_count_in  = byte_count_ff;
      running_sum_in = running_sum_ff;
      store_we       = 1'b0;
      result         = '0;
      result.status  = ST_IDLE;
      if (item.action) begin
         if (byte_count_ff != 4'd0) begin
            result.status = ST_SHORT;
         end
         byte_count_in  = 4'd0;
         running_sum_in = 8'd0;
      end else if ((byte_count_ff == 4'd0) && (item.rx_byte != HDR0)) begin
         result.status  = ST_HDR;
         byte_count_in  = 4'd0;
         running_sum_in = 8'd0;
      end else if ((byte_count_ff == 4'd1) && (item.rx_byte != HDR1)) begin
         result.status  = ST_HDR;
         byte_count_in  = 4'd0;
         running_sum_in = 8'd0;
      end else if (byte_count_ff < FRAME_FULL) begin
         store_we       = (byte_count_ff >= 4'd2);
         running_sum_in = running_sum_ff + item.rx_byte;
         byte_count_in  = byte_count_ff + 4'd1;
      end else begin
         // Checksum byte: the frame is complete.
         result.command_code = frame_ff[POS_CMD];
         result.data_high    = frame_ff[POS_DHIGH];
         result.data_low     = frame_ff[POS_DLOW];
         if (item.rx_byte != running_sum_ff) begin
            result.status = ST_CSUM;
         end else if (addr_own) begin
            result.status = len_ok ? ST_OWN : ST_BADLEN;
         end else if (addr_bcast) begin
            result.status = len_ok ? ST_BCAST : ST_BADLEN;
         end else begin
            result.status = ST_OTHER;
         end
         byte_count_in  = 4'd0;
         running_sum_in = 8'd0;
      end
   end

   // Count and sum registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff  <= 4'd0;
         running_sum_ff <= 8'd0;
      end else if (step) begin
         byte_count_ff  <= byte_count_in;
         running_sum_ff <= running_sum_in;
      end
   end

   // Frame byte store; entries are read only once the whole frame is in.
   always_ff @(posedge clock) begin
      if (step && store_we) begin
         frame_ff[store_idx] <= item.rx_byte;
      end
   end

   `AFR_ASSERT(a_count_range, clock, reset, byte_count_ff <= FRAME_FULL, "byte count above frame size")
   `AFR_ASSERT(a_empty_sum, clock, reset, (byte_count_ff == 4'd0) |-> (running_sum_ff == 8'd0), "sum not cleared with empty frame")
   `AFR_ASSERT(a_timeout_clears, clock, reset, (step && item.action) |=> (byte_count_ff == 4'd0), "timeout left a partial frame")
   `AFR_ASSERT(a_done_status, clock, reset, (step && !item.action && (byte_count_ff == FRAME_FULL)) |-> (result.status == ST_OWN || result.status == ST_BCAST || result.status == ST_CSUM || result.status == ST_OTHER || result.status == ST_BADLEN), "completed frame without a frame status")

endmodule

### sv/addressed_frame_receiver_unit.sv
// Addressed frame receiver.
// The req_ch channel carries one item per received byte (action 0) or per read
// timeout (action 1). The block assembles 9-byte frames: 0x00, 0x5A, group,
// device, command, length, data high, data low and an 8-bit sum checksum.
// The rsp_ch channel returns exactly one item per input item, in order; only
// the checksum byte of a frame yields a frame status with command and data.
// Own group and device addresses are written on the csr_ port (index 0 and 1);
// the user must do so only while no item is in flight; the block does not enforce it.
// An accepted item is held in the input register, then its result in the result
// register, from which it is offered on rsp_ch.
// Throughput: one item per cycle while rsp_ch takes results, set by the single update
// of the byte count and running sum between the input and result registers.
// When rsp_ch stalls, the result register holds and the input register keeps
// one more item; req_ch.ready drops only when both are full.
// Reset clears the frame in progress and both stages, and sets the node
// address to group 0xFF, device 0xFE.
module addressed_frame_receiver_unit
   import afr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   afr_req_if.sink       req_ch,
   afr_rsp_if.source     rsp_ch,
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [7:0]    csr_wdata
);

   logic [7:0]   own_group_addr_ff, own_device_addr_ff;
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;
   rsp_item_type core_result;
   logic         out_free, step, req_take;

   // Stage handshake: the input register moves on when the result register is free.
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign step         = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign in_valid_in  = req_take || (in_valid_ff && !step);
   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_ch.ready);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         own_group_addr_ff  <= DEFAULT_GROUP;
         own_device_addr_ff <= DEFAULT_DEVICE;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OWN_GROUP:  own_group_addr_ff  <= csr_wdata;
            CSR_OWN_DEVICE: own_device_addr_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.action  <= req_ch.action;
         in_item_ff.rx_byte <= req_ch.rx_byte;
      end
      if (step) begin
         rsp_item_ff <= core_result;
      end
   end

   // Frame assembly and classification.
   afr_frame_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .item       (in_item_ff),
      .own_group  (own_group_addr_ff),
      .own_device (own_device_addr_ff),
      .result     (core_result)
   );

   // Result channel.
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_item_ff.status;
   assign rsp_ch.command_code = rsp_item_ff.command_code;
   assign rsp_ch.data_high    = rsp_item_ff.data_high;
   assign rsp_ch.data_low     = rsp_item_ff.data_low;

endmodule
